// ===== design/shabh_pkg.sv =====
// Shared types and constants for the single-block SHA-256 hash engine.
// Standalone package: used by the channel interfaces and the top level.
package shabh_pkg;

  localparam int WordW       = 32;
  localparam int WindowDepth = 16;
  localparam int Rounds      = 64;
  localparam int DigestWords = 8;

  typedef logic [WordW-1:0] word_t;

  // Standard SHA-256 round constants
  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Standard SHA-256 initial hash value
  localparam word_t InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

// ===== design/shabh_msg_if.sv =====
// Input channel carrying message words, one 32-bit word per beat.
// Depends on shabh_pkg for the word type.
interface shabh_msg_if;
  logic            valid;
  logic            ready;
  shabh_pkg::word_t msg_word;

  modport source (output valid, output msg_word, input ready);
  modport sink   (input valid, input msg_word, output ready);
endinterface

// ===== design/shabh_dig_if.sv =====
// Output channel carrying digest words, one word per beat, last word marked.
// Depends on shabh_pkg for the word type.
interface shabh_dig_if;
  logic            valid;
  logic            ready;
  shabh_pkg::word_t digest_word;
  logic            digest_last;

  modport source (output valid, output digest_word, output digest_last, input ready);
  modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== design/sha256_block_hash.sv =====
// Single-block SHA-256 hash engine: one shared round unit under a small sequencer.
// Depends on shabh_pkg, shabh_msg_if and shabh_dig_if.
//
// Usage:
//   msg    : sixteen beats of msg_word make one padded 512-bit block, first
//            word first. ready is high only while the block is collecting words.
//   digest : eight beats of digest_word, H0 first; digest_last marks the eighth.
//   Every block is hashed from the standard initial value; no chaining.
// Timing:
//   One round unit does one compression round per cycle, and the message
//   schedule is expanded in the same cycle from a 16-word shift window.
//   After the sixteenth word the 64 rounds run, the FINISH state adds the
//   initial value back, then the eight digest beats follow, at most one per
//   cycle.
// Reset: synchronous; returns to word collection with an empty word count.
// Stall: while digest.ready is low the current digest word holds; no new
//   message word is taken until the last digest beat has gone out.
module sha256_block_hash (
  input  logic        clk,
  input  logic        rst,
  shabh_msg_if.sink   msg,
  shabh_dig_if.source digest
);

  typedef enum logic [1:0] {LOAD, ROUND, FINISH, EMIT} state_t;

  localparam int RoundW = $clog2(shabh_pkg::Rounds);
  localparam int OutW   = $clog2(shabh_pkg::DigestWords);
  localparam int CountW = $clog2(shabh_pkg::WindowDepth);

  state_t               state;
  logic [CountW-1:0]    word_count;
  logic [RoundW-1:0]    round;
  logic [OutW-1:0]      out_idx;
  shabh_pkg::word_t     window [shabh_pkg::WindowDepth];
  shabh_pkg::word_t     vars   [shabh_pkg::DigestWords];

  shabh_pkg::word_t w_new;
  shabh_pkg::word_t t1;
  shabh_pkg::word_t t2;

  function automatic shabh_pkg::word_t ror(shabh_pkg::word_t x, int unsigned n);
    ror = (x >> n) | (x << (shabh_pkg::WordW - n));
  endfunction

  function automatic shabh_pkg::word_t small_sig0(shabh_pkg::word_t x);
    small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic shabh_pkg::word_t small_sig1(shabh_pkg::word_t x);
    small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic shabh_pkg::word_t big_sig0(shabh_pkg::word_t x);
    big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic shabh_pkg::word_t big_sig1(shabh_pkg::word_t x);
    big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  // Expand the next schedule word; window[0] is the word used this round
  always_comb begin
    w_new = small_sig1(window[14]) + window[9] + small_sig0(window[1]) + window[0];
  end

  // Round unit: one compression round on the working variables
  always_comb begin
    t1 = vars[7] + big_sig1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
         + shabh_pkg::RoundK[round] + window[0];
    t2 = big_sig0(vars[0]) + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  assign msg.ready          = (state == LOAD);
  assign digest.valid       = (state == EMIT);
  assign digest.digest_word = vars[0];
  assign digest.digest_last = (out_idx == OutW'(shabh_pkg::DigestWords - 1));

  // Sequencer: collect words, run rounds, add initial value, emit digest
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LOAD;
      word_count <= '0;
      round      <= '0;
      out_idx    <= '0;
      for (int i = 0; i < shabh_pkg::DigestWords; i++) begin
        vars[i] <= '0;
      end
    end else begin
      case (state)
        LOAD: begin
          if (msg.valid) begin
            // shift the word in at the top of the window
            for (int i = 0; i < shabh_pkg::WindowDepth - 1; i++) begin
              window[i] <= window[i+1];
            end
            window[shabh_pkg::WindowDepth-1] <= msg.msg_word;
            word_count <= word_count + 1'b1;
            if (word_count == CountW'(shabh_pkg::WindowDepth - 1)) begin
              for (int i = 0; i < shabh_pkg::DigestWords; i++) begin
                vars[i] <= shabh_pkg::InitHash[i];
              end
              round <= '0;
              state <= ROUND;
            end
          end
        end
        ROUND: begin
          // advance the schedule window and the working variables
          for (int i = 0; i < shabh_pkg::WindowDepth - 1; i++) begin
            window[i] <= window[i+1];
          end
          window[shabh_pkg::WindowDepth-1] <= w_new;
          vars[7] <= vars[6];
          vars[6] <= vars[5];
          vars[5] <= vars[4];
          vars[4] <= vars[3] + t1;
          vars[3] <= vars[2];
          vars[2] <= vars[1];
          vars[1] <= vars[0];
          vars[0] <= t1 + t2;
          round   <= round + 1'b1;
          if (round == RoundW'(shabh_pkg::Rounds - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          // add the initial hash value back
          for (int i = 0; i < shabh_pkg::DigestWords; i++) begin
            vars[i] <= vars[i] + shabh_pkg::InitHash[i];
          end
          out_idx <= '0;
          state   <= EMIT;
        end
        EMIT: begin
          // drop the sent word and bring up the next one
          if (digest.ready) begin
            for (int i = 0; i < shabh_pkg::DigestWords - 1; i++) begin
              vars[i] <= vars[i+1];
            end
            out_idx <= out_idx + 1'b1;
            if (out_idx == OutW'(shabh_pkg::DigestWords - 1)) begin
              state <= LOAD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule
